// ===== hw/rtl/mbc1_bank_mapper_core_macros.svh =====
// Assertion macros used by the mapper's checker file.
`ifndef MBC1_BANK_MAPPER_CORE_MACROS_SVH
`define MBC1_BANK_MAPPER_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define MBC1_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define MBC1_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mbc1bm_pkg.sv =====
// Types and constants of the bank mapper core.
package mbc1bm_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PHYS_W     = 21;
  localparam int unsigned ROM_BANK_W = 7;
  localparam int unsigned RAM_BANK_W = 2;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned TARGET_W   = 3;

  localparam logic [DATA_W-1:0] RAM_ENABLE_KEY  = 8'h0A;
  localparam logic [DATA_W-1:0] RAM_DISABLE_KEY = 8'h00;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

  typedef enum logic [TARGET_W-1:0] {
    TGT_INTERNAL = 3'd0,
    TGT_ROM      = 3'd1,
    TGT_RAM      = 3'd2,
    TGT_CONTROL  = 3'd3,
    TGT_DROPPED  = 3'd4
  } target_t;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_t;

  // Control range selected by address bits 14:13 below 0x8000.
  typedef enum logic [1:0] {
    CTL_RAM_ENABLE = 2'b00,
    CTL_ROM_LOW    = 2'b01,
    CTL_UPPER_BANK = 2'b10,
    CTL_MODE       = 2'b11
  } ctl_range_t;

endpackage

// ===== hw/rtl/mbc1_bank_mapper_core.sv =====
// Bank mapper core: maps CPU bus accesses to internal memory, cartridge ROM or RAM.
//
// Channel  Direction  tdata (low bit up)                   tuser
// in       slave      bus_address[15:0], write_data[23:16] func[0]
// out      master     physical_address[20:0], zero[23:21]  target[2:0]
// cfg      slave      mapper_present[0]                    -
//
// One word is accepted per cycle unless the output stalls.
// The input register feeds one level of decode and bank arithmetic into the result register.
// Bank state is updated as a control write moves into the result register, so the next word
// already sees it. Reset is synchronous and returns all bank state and both valid flags to
// their reset values.
// A stalled output holds its word while one more input word may wait in the input register.
module mbc1_bank_mapper_core
  import mbc1bm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // bus_address[15:0], write_data[23:16]
  input  logic [0:0]             in_tuser,   // func[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // physical_address[20:0], zero[23:21]
  output logic [TARGET_W-1:0]    out_tuser,  // target[2:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data    // mapper_present[0]
);

  logic                  mapper_present_r;
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  ram_en_r, ram_en_nxt;
  logic                  bank_mode_r, bank_mode_nxt;

  logic                  s1_valid_r;
  access_t               s1_func_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [DATA_W-1:0]     s1_data_r;

  logic                  out_valid_r;
  target_t               out_tgt_r, out_tgt_nxt;
  logic [PHYS_W-1:0]     out_phys_r, out_phys_nxt;

  logic                  s1_adv;
  logic                  s1_fire;
  logic                  in_fire;
  logic                  in_ram;
  logic [4:0]            rom_low;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_ram  = (s1_addr_r[15:13] == 3'b101);
  assign rom_low = (s1_data_r[4:0] == 5'd0) ? 5'd1 : s1_data_r[4:0];

  always_comb begin
    out_tgt_nxt   = TGT_INTERNAL;
    out_phys_nxt  = {{(PHYS_W-ADDR_W){1'b0}}, s1_addr_r};
    rom_bank_nxt  = rom_bank_r;
    ram_bank_nxt  = ram_bank_r;
    ram_en_nxt    = ram_en_r;
    bank_mode_nxt = bank_mode_r;
    if (mapper_present_r) begin
      if (in_ram && ram_en_r) begin
        out_tgt_nxt  = TGT_RAM;
        out_phys_nxt = {{(PHYS_W-RAM_BANK_W-13){1'b0}}, ram_bank_r, s1_addr_r[12:0]};
      end else if (s1_func_r == ACC_READ) begin
        if (s1_addr_r[15:14] == 2'b01) begin
          out_tgt_nxt  = TGT_ROM;
          out_phys_nxt = {rom_bank_r, s1_addr_r[13:0]};
        end
      end else if (!s1_addr_r[15]) begin
        out_tgt_nxt  = TGT_CONTROL;
        out_phys_nxt = '0;
        unique case (ctl_range_t'(s1_addr_r[14:13]))
          CTL_RAM_ENABLE: begin
            if (s1_data_r == RAM_ENABLE_KEY) begin
              ram_en_nxt = 1'b1;
            end else if (s1_data_r == RAM_DISABLE_KEY) begin
              ram_en_nxt = 1'b0;
            end
          end
          CTL_ROM_LOW: begin
            rom_bank_nxt = {rom_bank_r[6:5], rom_low};
          end
          CTL_UPPER_BANK: begin
            if (!bank_mode_r) begin
              rom_bank_nxt = {s1_data_r[1:0], rom_bank_r[4:0]};
            end else begin
              ram_bank_nxt = s1_data_r[1:0];
            end
          end
          CTL_MODE: begin
            bank_mode_nxt = s1_data_r[0];
          end
          default: begin
            bank_mode_nxt = bank_mode_r;
          end
        endcase
      end
    end else if (s1_func_r == ACC_WRITE && !s1_addr_r[15]) begin
      out_tgt_nxt  = TGT_DROPPED;
      out_phys_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_present_r <= 1'b0;
      rom_bank_r       <= ROM_BANK_RESET;
      ram_bank_r       <= '0;
      ram_en_r         <= 1'b0;
      bank_mode_r      <= 1'b0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mapper_present_r <= cfg_data[0];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        rom_bank_r  <= rom_bank_nxt;
        ram_bank_r  <= ram_bank_nxt;
        ram_en_r    <= ram_en_nxt;
        bank_mode_r <= bank_mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= access_t'(in_tuser[0]);
      s1_addr_r <= in_tdata[ADDR_W-1:0];
      s1_data_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
    if (s1_fire) begin
      out_tgt_r  <= out_tgt_nxt;
      out_phys_r <= out_phys_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tgt_r;
  assign out_tdata  = {{(OUT_TDATA_W-PHYS_W){1'b0}}, out_phys_r};

endmodule

// ===== hw/rtl/mbc1bm_checker.sv =====
// Port-level checker of the bank mapper core and its bind statement.
`include "mbc1_bank_mapper_core_macros.svh"

module mbc1bm_checker
  import mbc1bm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,  // physical_address[20:0], zero[23:21]
  input logic [TARGET_W-1:0]    out_tuser   // target[2:0]
);

  `MBC1_ASSERT_ANY(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `MBC1_ASSERT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled word changed")
  `MBC1_ASSERT(a_rom_bank_nonzero, clk, rst_n, out_tvalid && out_tuser == TGT_ROM |-> out_tdata[18:14] != 5'd0, "ROM bank low bits zero")
  `MBC1_ASSERT(a_ctl_zero_addr, clk, rst_n, out_tvalid && (out_tuser == TGT_CONTROL || out_tuser == TGT_DROPPED) |-> out_tdata == '0, "control or dropped word has an address")
  `MBC1_ASSERT(a_ram_in_range, clk, rst_n, out_tvalid && out_tuser == TGT_RAM |-> out_tdata[OUT_TDATA_W-1:15] == '0, "RAM address beyond four banks")

endmodule

bind mbc1_bank_mapper_core mbc1bm_checker u_mbc1bm_checker (.*);
